[src/sorted_set_insert_lookup_assert.svh]
// ----------------------------------------------------------------------------
// Sorted set assertion macros
// Concurrent check wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_LOOKUP_ASSERT_SVH
`define SORTED_SET_INSERT_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSIL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted set check failed");
// next-cycle implication
`define SSIL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted set check failed");
`else
`define SSIL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SSIL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/ssil_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted set package
// Command codes, field widths and the control word shared by the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ssil_pkg;

  localparam int ValueW    = 32;
  localparam int RankW     = 4;
  localparam int SizeW     = 5;
  localparam int CmdW      = 2;
  localparam int ReadSlots = 16;

  localparam logic [CmdW-1:0] CmdInsert = 2'd0;
  localparam logic [CmdW-1:0] CmdQuery  = 2'd1;
  localparam logic [CmdW-1:0] CmdRead   = 2'd2;

  // broadcast to every cell
  typedef struct packed {
    logic              shift_en;
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[src/ssil_cell.sv]
// ----------------------------------------------------------------------------
// Sorted set cell
// One entry of the ordered chain: compares against the broadcast value and on
// insert takes either the value or its left neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ssil_cell import ssil_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic              live_i,
  input  logic              left_above_i,
  input  logic [ValueW-1:0] left_entry_i,
  output logic              above_o,
  output logic              match_o,
  output logic [ValueW-1:0] entry_o
);

  logic [ValueW-1:0] entry_q, entry_d;

  // empty cells count as above so the first empty slot takes the value
  assign above_o = !live_i || ($signed(entry_q) > $signed(ctrl_i.value));
  assign match_o = live_i && (entry_q == ctrl_i.value);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_en && above_o) begin
      entry_d = left_above_i ? left_entry_i : ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

[src/sorted_set_insert_lookup.sv]
// ----------------------------------------------------------------------------
// Sorted set with insert, membership query and read by rank
// Ascending set of distinct signed words held in a chain of compare/shift
// cells; one result word per command word.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  command   | start & !busy        | cmd_i, value_i, rank_i
//  result    | done_o (one cycle)   | found_o, inserted_o, dropped_full_o,
//            |                      | size_now_o, element_o, element_valid_o
//
//  A command is latched at the accept edge; the next cycle runs the parallel
//  compare in every cell, the OR of the match flags and the one-step shift;
//  done_o is registered from that compare cycle. busy is high for that
//  compare cycle only, so a new command is taken while done_o reports the last.
//  Reset clears the element count; the cell entries are not reset.
//  The result side has no stall: done_o is high for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_set_insert_lookup_assert.svh"

module sorted_set_insert_lookup import ssil_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [ValueW-1:0] value_i,
  input  logic [RankW-1:0]  rank_i,
  output logic              done_o,
  output logic              found_o,
  output logic              inserted_o,
  output logic              dropped_full_o,
  output logic [SizeW-1:0]  size_now_o,
  output logic [ValueW-1:0] element_o,
  output logic              element_valid_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic              op_q;
  logic [CmdW-1:0]   cmd_q;
  logic [ValueW-1:0] value_q;
  logic [RankW-1:0]  rank_q;
  logic [CntW-1:0]   count_q, count_d;

  logic              done_q, found_q, inserted_q, dropped_q, elem_vld_q;
  logic [SizeW-1:0]  size_q;
  logic [ValueW-1:0] element_q;

  logic [CAPACITY-1:0]             live, above, match;
  logic [CAPACITY-1:0][ValueW-1:0] cell_entry;
  logic [ReadSlots-1:0][ValueW-1:0] rd_vec;
  cell_ctrl_t                      ctrl;

  logic accept, present, full, is_ins, do_ins, rank_ok, rd_ok;
  logic found_d, dropped_d;
  logic [ValueW-1:0] element_d;

  assign busy   = op_q;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= 1'b0;
    end else begin
      op_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      value_q <= value_i;
      rank_q  <= rank_i;
    end
  end

  // cell chain
  assign ctrl.shift_en = do_ins;
  assign ctrl.value    = value_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              left_above;
    logic [ValueW-1:0] left_entry;

    assign live[i] = count_q > CntW'(i);

    if (i == 0) begin : g_head
      assign left_above = 1'b0;
      assign left_entry = '0;
    end else begin : g_body
      assign left_above = above[i-1];
      assign left_entry = cell_entry[i-1];
    end

    ssil_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .live_i       (live[i]),
      .left_above_i (left_above),
      .left_entry_i (left_entry),
      .above_o      (above[i]),
      .match_o      (match[i]),
      .entry_o      (cell_entry[i])
    );
  end

  for (genvar r = 0; r < ReadSlots; r++) begin : g_rd
    if (r < CAPACITY) begin : g_tap
      assign rd_vec[r] = cell_entry[r];
    end else begin : g_none
      assign rd_vec[r] = '0;
    end
  end

  // decode
  assign present = |match;
  assign full    = count_q == CntW'(CAPACITY);
  assign is_ins  = op_q && (cmd_q == CmdInsert);
  assign do_ins  = is_ins && !present && !full;
  assign count_d = count_q + CntW'(do_ins);

  assign found_d   = op_q && ((cmd_q == CmdInsert) || (cmd_q == CmdQuery)) && present;
  assign dropped_d = is_ins && !present && full;
  assign rank_ok   = (32'(rank_q) < 32'(count_q)) && (32'(rank_q) < 32'(CAPACITY));
  assign rd_ok     = op_q && (cmd_q == CmdRead) && rank_ok;
  assign element_d = rd_ok ? rd_vec[rank_q] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= op_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_q) begin
      found_q    <= found_d;
      inserted_q <= do_ins;
      dropped_q  <= dropped_d;
      size_q     <= SizeW'(count_d);
      element_q  <= element_d;
      elem_vld_q <= rd_ok;
    end
  end

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign inserted_o      = inserted_q;
  assign dropped_full_o  = dropped_q;
  assign size_now_o      = size_q;
  assign element_o       = element_q;
  assign element_valid_o = elem_vld_q;

  // checks
  `SSIL_ASSERT_IMP(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CntW'(CAPACITY))
  `SSIL_ASSERT_IMP(a_flags_excl, clk_i, rst_ni, done_q,
                   $onehot0({found_q, inserted_q, dropped_q, elem_vld_q}))
  `SSIL_ASSERT_NXT(a_cmd_done, clk_i, rst_ni, op_q, done_q && !op_q)
  `SSIL_ASSERT_IMP(a_ins_grow, clk_i, rst_ni, done_q && inserted_q,
                   count_q == CntW'($past(count_q) + 1'b1))

endmodule

`default_nettype wire
